/* rtl/core/length_prefixed_frame_deframer_core_assert.svh */
// Assertion macros for the deframer core.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LPFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpfd: implication check failed");

// next-cycle implication
`define LPFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpfd: next-cycle check failed");

`else

`define LPFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/lpfd_pkg.sv */
package lpfd_pkg;

    localparam int unsigned HDR_BYTES  = 10;
    localparam int unsigned HDR_CNT_W  = $clog2(HDR_BYTES);
    localparam int unsigned LEN_W      = 31;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0]      MAGIC_RST   = 32'h4642_4542;  // "FBEB"
    localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b1;

    typedef enum logic [1:0] {
        ST_PAYLOAD    = 2'd0,
        ST_BAD_MAGIC  = 2'd1,
        ST_BAD_LENGTH = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [7:0]         payload_byte;
        logic [15:0]        event_id;
        logic signed [31:0] frame_length;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [31:0]      magic;
        logic [LEN_W-1:0] max_len;
    } t_cfg;

endpackage

/* rtl/core/lpfd_cfg.sv */
module lpfd_cfg
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_MAGIC:   n_cfg.magic   = i_cfg_wr_data;
                CFG_MAX_LEN: n_cfg.max_len = i_cfg_wr_data[LEN_W-1:0];
                default:     n_cfg         = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= MAGIC_RST;
            r_cfg.max_len <= MAX_LEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/lpfd_hdr.sv */
`include "length_prefixed_frame_deframer_core_assert.svh"

module lpfd_hdr
    import lpfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [HDR_CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0]           r_event, n_event;
    logic [LEN_W-1:0]      r_pay_len, n_pay_len;
    logic [LEN_W-1:0]      r_pay_cnt, n_pay_cnt;
    // last header byte is taken straight from the input, so one entry less
    logic [7:0]            r_hdr_store [HDR_BYTES-1];

    logic        hdr_last;
    logic [31:0] hdr_magic;
    logic [15:0] hdr_event;
    logic [31:0] hdr_len;
    logic        bad_magic;
    logic        bad_len;
    logic [LEN_W-1:0] pay_cnt_inc;
    logic        pay_end;
    logic        res_valid;
    t_result     res;

    assign hdr_last  = (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1));
    assign hdr_magic = {r_hdr_store[0], r_hdr_store[1], r_hdr_store[2], r_hdr_store[3]};
    assign hdr_event = {r_hdr_store[5], r_hdr_store[4]};
    assign hdr_len   = {i_rx_byte, r_hdr_store[8], r_hdr_store[7], r_hdr_store[6]};
    assign bad_magic = (hdr_magic != i_cfg.magic);
    // sign bit set, zero, or above the limit
    assign bad_len   = hdr_len[31] || (hdr_len[LEN_W-1:0] == '0)
                       || (hdr_len[LEN_W-1:0] > i_cfg.max_len);

    assign pay_cnt_inc = r_pay_cnt + LEN_W'(1);
    assign pay_end     = (pay_cnt_inc >= r_pay_len);

    always_comb begin
        res_valid        = 1'b0;
        res.status       = ST_PAYLOAD;
        res.payload_byte = 8'd0;
        res.event_id     = r_event;
        res.frame_length = $signed({1'b0, r_pay_len});
        res.last         = 1'b0;
        n_phase          = r_phase;
        n_hdr_cnt        = r_hdr_cnt;
        n_event          = r_event;
        n_pay_len        = r_pay_len;
        n_pay_cnt        = r_pay_cnt;

        case (r_phase)
            PH_HEADER: begin
                if (hdr_last) begin
                    n_hdr_cnt        = '0;
                    n_event          = hdr_event;
                    res.event_id     = hdr_event;
                    res.frame_length = $signed(hdr_len);
                    res.last         = 1'b1;
                    if (bad_magic) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_MAGIC;
                    end else if (bad_len) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_LENGTH;
                    end else begin
                        n_pay_len = hdr_len[LEN_W-1:0];
                        n_pay_cnt = '0;
                        n_phase   = PH_PAYLOAD;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                end
            end
            PH_PAYLOAD: begin
                res_valid        = 1'b1;
                res.payload_byte = i_rx_byte;
                res.last         = pay_end;
                if (pay_end) begin
                    n_phase   = PH_HEADER;
                    n_pay_cnt = '0;
                    n_hdr_cnt = '0;
                end else begin
                    n_pay_cnt = pay_cnt_inc;
                end
            end
            default: begin
                n_phase   = PH_HEADER;
                n_hdr_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_event   <= '0;
            r_pay_len <= '0;
            r_pay_cnt <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_event   <= n_event;
            r_pay_len <= n_pay_len;
            r_pay_cnt <= n_pay_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (r_phase == PH_HEADER) && !hdr_last) begin
            r_hdr_store[r_hdr_cnt] <= i_rx_byte;
        end
    end

    assign o_res_valid = i_accept && res_valid;
    assign o_res       = res;

    `LPFD_ASSERT_IMP(a_hdr_cnt_range, i_clk, i_rst_n, 1'b1, r_hdr_cnt <= HDR_CNT_W'(HDR_BYTES - 1))
    `LPFD_ASSERT_IMP(a_pay_cnt_below_len, i_clk, i_rst_n, r_phase == PH_PAYLOAD, r_pay_cnt < r_pay_len)
    `LPFD_ASSERT_NXT(a_good_hdr_to_payload, i_clk, i_rst_n, i_accept && (r_phase == PH_HEADER) && hdr_last && !bad_magic && !bad_len, (r_phase == PH_PAYLOAD) && (r_hdr_cnt == '0))

endmodule

/* rtl/core/lpfd_obuf.sv */
`include "length_prefixed_frame_deframer_core_assert.svh"

module lpfd_obuf
    import lpfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_main_valid && !i_stall;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // input is held off while the skid beat is pending
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_res;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign o_full  = r_skid_valid;

    `LPFD_ASSERT_IMP(a_skid_needs_main, i_clk, i_rst_n, r_skid_valid, r_main_valid)
    `LPFD_ASSERT_IMP(a_error_is_last, i_clk, i_rst_n, r_main_valid && (r_main.status != ST_PAYLOAD), r_main.last && (r_main.payload_byte == 8'd0))

endmodule

/* rtl/core/length_prefixed_frame_deframer_core.sv */
// channel   valid     stall     payload
// -------   -------   -------   ---------------------------------------------
// in        i_valid   o_stall   i_rx_byte
// out       o_valid   i_stall   o_status o_payload_byte o_event_id
//                               o_frame_length o_last
// One rx byte per cycle while o_stall is low; each result is registered in the output buffer.
// The header/payload counters update once per accepted beat.
// i_rst_n is synchronous: counters clear, output empties, config returns to defaults.
// A two-entry output buffer parts the sides; o_stall rises only when both entries are full.
module length_prefixed_frame_deframer_core
    import lpfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_status,
    output logic [7:0]            o_payload_byte,
    output logic [15:0]           o_event_id,
    output logic signed [31:0]    o_frame_length,
    output logic                  o_last,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    t_cfg    cfg;
    t_result res;
    t_result out_res;
    logic    res_valid;
    logic    full;
    logic    accept;

    assign accept  = i_valid && !full;
    assign o_stall = full;

    lpfd_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    lpfd_hdr u_hdr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpfd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_full  (full)
    );

    assign o_status       = out_res.status;
    assign o_payload_byte = out_res.payload_byte;
    assign o_event_id     = out_res.event_id;
    assign o_frame_length = out_res.frame_length;
    assign o_last         = out_res.last;

endmodule
